// ===== rtl/tcvw_pkg.sv =====
`timescale 1ns / 1ps

package tcvw_pkg;

   // Field widths of the stream payloads.
   localparam int ChanW     = 24;
   localparam int MarkW     = 4;
   localparam int WidthW    = 5;
   localparam int WordW     = 32;
   localparam int CountW    = 4;
   localparam int NumLanes  = 3;
   localparam int NumWords  = 3;
   localparam int RecW      = NumWords * WordW;
   localparam int PosW      = 7;
   localparam int ChanBitsW = 5;
   localparam int CodeW     = 4;
   localparam int CodeLenW  = 3;
   localparam int WordIdxW  = 2;
   localparam int HdrW      = MarkW + CodeW;
   localparam int ReqDataW  = 88;
   localparam int RspDataW  = 40;

   // Literal format codes; a 3-bit code lives in the low three bits.
   localparam logic [CodeW-1:0] CODE_W0  = 4'b0000;
   localparam logic [CodeW-1:0] CODE_W3  = 4'b0100;
   localparam logic [CodeW-1:0] CODE_W5  = 4'b0001;
   localparam logic [CodeW-1:0] CODE_W8  = 4'b0010;
   localparam logic [CodeW-1:0] CODE_W11 = 4'b0101;
   localparam logic [CodeW-1:0] CODE_W13 = 4'b0011;
   localparam logic [CodeW-1:0] CODE_W16 = 4'b0100;
   localparam logic [CodeW-1:0] CODE_W19 = 4'b0110;
   localparam logic [CodeW-1:0] CODE_W21 = 4'b0110;
   localparam logic [CodeW-1:0] CODE_W24 = 4'b0111;

   localparam logic [CodeLenW-1:0] CODE_LEN_SHORT = 3'd3;
   localparam logic [CodeLenW-1:0] CODE_LEN_LONG  = 3'd4;

   typedef struct packed {
      logic [ChanBitsW-1:0] chan_bits;
      logic [CodeW-1:0]     code;
      logic [CodeLenW-1:0]  code_len;
      logic [CountW-1:0]    bytes;
   } fmt_type;

   typedef struct packed {
      logic [ChanBitsW-1:0] chan_bits;
      logic [PosW-1:0]      pos;
   } lane_ctl_type;

   typedef struct packed {
      logic [HdrW-1:0]     hdr;
      logic [CountW-1:0]   bytes;
      logic [WordIdxW-1:0] nwords;
   } meta_type;

   // Maps the requested width per channel onto one of the ten formats.
   function automatic fmt_type fmt_of(input logic [WidthW-1:0] w);
      fmt_type f;
      if (w == 5'd0)       f = '{5'd0,  CODE_W0,  CODE_LEN_LONG,  4'd1};
      else if (w <= 5'd3)  f = '{5'd3,  CODE_W3,  CODE_LEN_SHORT, 4'd2};
      else if (w <= 5'd5)  f = '{5'd5,  CODE_W5,  CODE_LEN_LONG,  4'd3};
      else if (w <= 5'd8)  f = '{5'd8,  CODE_W8,  CODE_LEN_LONG,  4'd4};
      else if (w <= 5'd11) f = '{5'd11, CODE_W11, CODE_LEN_SHORT, 4'd5};
      else if (w <= 5'd13) f = '{5'd13, CODE_W13, CODE_LEN_LONG,  4'd6};
      else if (w <= 5'd16) f = '{5'd16, CODE_W16, CODE_LEN_LONG,  4'd7};
      else if (w <= 5'd19) f = '{5'd19, CODE_W19, CODE_LEN_SHORT, 4'd8};
      else if (w <= 5'd21) f = '{5'd21, CODE_W21, CODE_LEN_LONG,  4'd9};
      else                 f = '{5'd24, CODE_W24, CODE_LEN_LONG,  4'd10};
      return f;
   endfunction

   // Bit-reverses a code within its own length.
   function automatic logic [CodeW-1:0] code_reverse(input logic [CodeW-1:0] c,
                                                     input logic [CodeLenW-1:0] len);
      logic [CodeW-1:0] r;
      if (len == CODE_LEN_SHORT) r = {1'b0, c[0], c[1], c[2]};
      else                       r = {c[0], c[1], c[2], c[3]};
      return r;
   endfunction

endpackage

// ===== rtl/tcvw_lane.sv =====
`timescale 1ns / 1ps

// One channel lane: masks the channel to the format width and moves it to
// its place in the record.
module tcvw_lane (
   input  logic                               clock,
   input  logic                               load,
   input  logic [tcvw_pkg::ChanW-1:0]         chan,
   input  tcvw_pkg::lane_ctl_type             ctl,
   output logic [tcvw_pkg::RecW-1:0]          lane_vec
);

   logic [tcvw_pkg::ChanW:0]    mask_full;
   logic [tcvw_pkg::ChanW-1:0]  masked;
   logic [tcvw_pkg::RecW-1:0]   vec_in;
   logic [tcvw_pkg::RecW-1:0]   vec_ff;

   always_comb begin
      mask_full = ((tcvw_pkg::ChanW+1)'(1) << ctl.chan_bits) - (tcvw_pkg::ChanW+1)'(1);
      masked    = chan & mask_full[tcvw_pkg::ChanW-1:0];
      vec_in    = tcvw_pkg::RecW'(masked) << ctl.pos;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vec_ff <= vec_in;
      end
   end

   assign lane_vec = vec_ff;

endmodule

// ===== rtl/tcvw_merge.sv =====
`timescale 1ns / 1ps

// Combines the header with the three lane vectors into one record and sends
// it out one 32-bit word per transaction.
module tcvw_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  tcvw_pkg::meta_type                   meta,
   input  logic [tcvw_pkg::RecW-1:0]            lane0_vec,
   input  logic [tcvw_pkg::RecW-1:0]            lane1_vec,
   input  logic [tcvw_pkg::RecW-1:0]            lane2_vec,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [tcvw_pkg::RspDataW-1:0]        rsp_tdata,
   output logic                                 rsp_tlast
);

   logic                              valid_ff, valid_in;
   logic [tcvw_pkg::RecW-1:0]         rec_ff, rec_in;
   logic [tcvw_pkg::CountW-1:0]       bytes_ff;
   logic [tcvw_pkg::WordIdxW-1:0]     nwords_ff;
   logic [tcvw_pkg::WordIdxW-1:0]     idx_ff, idx_in;
   logic [tcvw_pkg::WordW-1:0]        word;
   logic                              last;
   logic                              xfer, done, load;

   always_comb begin
      rec_in = tcvw_pkg::RecW'(meta.hdr) | lane0_vec | lane1_vec | lane2_vec;
      case (idx_ff)
         2'd0:    word = rec_ff[31:0];
         2'd1:    word = rec_ff[63:32];
         2'd2:    word = rec_ff[95:64];
         default: word = '0;
      endcase
      last     = (idx_ff == nwords_ff - 2'd1);
      xfer     = valid_ff && rsp_tready;
      done     = xfer && last;
      in_ready = !valid_ff || done;
      load     = in_valid && in_ready;
      if (load)      valid_in = 1'b1;
      else if (done) valid_in = 1'b0;
      else           valid_in = valid_ff;
      if (load)      idx_in = '0;
      else if (xfer) idx_in = idx_ff + 2'd1;
      else           idx_in = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff    <= rec_in;
         bytes_ff  <= meta.bytes;
         nwords_ff <= meta.nwords;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0000, bytes_ff, word};
   assign rsp_tlast  = last;

   // The word index never runs past the record's word count.
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff < nwords_ff))
      else $error("word index beyond record length");

   // A record of more than four bytes never ends on its first word.
   a_multi_word: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && idx_ff == 2'd0 && bytes_ff > 4'd4) |-> !last)
      else $error("multi-word record ends early");

   // A new record is loaded only when the previous one has fully left.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !done) |-> !in_ready)
      else $error("record overwritten before last word");

endmodule

// ===== rtl/three_channel_variable_width_packer.sv =====
`timescale 1ns / 1ps
// Throughput: one word per cycle while rsp_tready is high; a record is 1, 2 or 3 words
// by its byte count (1..4, 5..8, 9..10 bytes), set by the single 32-bit result port.
// A new request is taken every cycle that the three-stage pipeline has room.
// Reset (synchronous, active high) empties the pipeline and clears reversed_codes.

// Three-channel variable-width packer. The request stage decodes the bit width
// into a format and works out where each channel lands in the record. Three
// channel lanes then mask and shift their channel in parallel, and the merge
// stage ORs the lanes with the mark and format code and streams the record
// out as one to three 32-bit words.
module three_channel_variable_width_packer (
   input  logic                                clock,
   input  logic                                reset,
   // Request: [23:0] first_channel, [47:24] second_channel,
   // [71:48] third_channel, [75:72] event_mark, [80:76] bit_width.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tcvw_pkg::ReqDataW-1:0]       req_tdata,
   // Response: [31:0] packed_word, [35:32] byte_count; tlast is last_word.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tcvw_pkg::RspDataW-1:0]       rsp_tdata,
   output logic                                rsp_tlast,
   // Register file: one register, reversed_codes, at byte address 0.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [2:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   localparam logic REG_REVERSED_CODES = 1'b0;

   // Configuration register. Only address bit 2 selects a register, so
   // writes to the next word are ignored.
   logic cfg_rev_ff, cfg_rev_in;
   logic cfg_write;

   always_comb begin
      cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
      cfg_rev_in = cfg_rev_ff;
      if (cfg_write && csr_paddr[2] == REG_REVERSED_CODES) begin
         cfg_rev_in = csr_pwdata[0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_REVERSED_CODES) ? {31'd0, cfg_rev_ff} : 32'd0;

   // Request fields.
   logic [tcvw_pkg::ChanW-1:0]   req_chan [tcvw_pkg::NumLanes];
   logic [tcvw_pkg::MarkW-1:0]   req_mark;
   logic [tcvw_pkg::WidthW-1:0]  req_width;

   assign req_chan[0] = req_tdata[23:0];
   assign req_chan[1] = req_tdata[47:24];
   assign req_chan[2] = req_tdata[71:48];
   assign req_mark    = req_tdata[75:72];
   assign req_width   = req_tdata[80:76];

   // Format decode and lane placement for the incoming transaction.
   tcvw_pkg::fmt_type           fmt;
   logic [tcvw_pkg::CodeW-1:0]  code;
   logic [tcvw_pkg::PosW-1:0]   pos0, pos1, pos2;
   tcvw_pkg::lane_ctl_type      ctl_in [tcvw_pkg::NumLanes];
   tcvw_pkg::meta_type          meta_in;

   always_comb begin
      fmt  = tcvw_pkg::fmt_of(req_width);
      code = cfg_rev_ff ? tcvw_pkg::code_reverse(fmt.code, fmt.code_len) : fmt.code;
      // Channels start right after the code, which is three or four bits long.
      pos0 = tcvw_pkg::PosW'(tcvw_pkg::MarkW) + tcvw_pkg::PosW'(fmt.code_len);
      pos1 = pos0 + tcvw_pkg::PosW'(fmt.chan_bits);
      pos2 = pos1 + tcvw_pkg::PosW'(fmt.chan_bits);
      ctl_in[0] = '{fmt.chan_bits, pos0};
      ctl_in[1] = '{fmt.chan_bits, pos1};
      ctl_in[2] = '{fmt.chan_bits, pos2};
      meta_in.hdr    = {code, req_mark};
      meta_in.bytes  = fmt.bytes;
      // Words in the record: the byte count rounded up to whole words.
      meta_in.nwords = fmt.bytes[3:2] + {1'b0, |fmt.bytes[1:0]};
   end

   // Pipeline control. Each stage takes a new transaction when it is empty
   // or when its contents move on in the same cycle.
   logic a_valid_ff, a_valid_in;
   logic l_valid_ff, l_valid_in;
   logic a_ready, l_ready, a_load, l_load;
   logic merge_ready, merge_load;

   always_comb begin
      l_ready    = !l_valid_ff || merge_ready;
      a_ready    = !a_valid_ff || l_ready;
      a_load     = req_tvalid && a_ready;
      l_load     = a_valid_ff && l_ready;
      merge_load = l_valid_ff && merge_ready;
      if (a_load)      a_valid_in = 1'b1;
      else if (l_load) a_valid_in = 1'b0;
      else             a_valid_in = a_valid_ff;
      if (l_load)          l_valid_in = 1'b1;
      else if (merge_load) l_valid_in = 1'b0;
      else                 l_valid_in = l_valid_ff;
   end

   assign req_tready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_rev_ff <= 1'b0;
         a_valid_ff <= 1'b0;
         l_valid_ff <= 1'b0;
      end else begin
         cfg_rev_ff <= cfg_rev_in;
         a_valid_ff <= a_valid_in;
         l_valid_ff <= l_valid_in;
      end
   end

   // Decode stage payload.
   logic [tcvw_pkg::ChanW-1:0] a_chan_ff [tcvw_pkg::NumLanes];
   tcvw_pkg::lane_ctl_type     a_ctl_ff  [tcvw_pkg::NumLanes];
   tcvw_pkg::meta_type         a_meta_ff;
   tcvw_pkg::meta_type         l_meta_ff;

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_chan_ff <= req_chan;
         a_ctl_ff  <= ctl_in;
         a_meta_ff <= meta_in;
      end
      if (l_load) begin
         l_meta_ff <= a_meta_ff;
      end
   end

   // Channel lanes.
   logic [tcvw_pkg::RecW-1:0] lane_vec [tcvw_pkg::NumLanes];

   for (genvar g = 0; g < tcvw_pkg::NumLanes; g++) begin : g_lane
      tcvw_lane u_lane (
         .clock    (clock),
         .load     (l_load),
         .chan     (a_chan_ff[g]),
         .ctl      (a_ctl_ff[g]),
         .lane_vec (lane_vec[g])
      );
   end

   // Merge and word output.
   tcvw_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (l_valid_ff),
      .in_ready   (merge_ready),
      .meta       (l_meta_ff),
      .lane0_vec  (lane_vec[0]),
      .lane1_vec  (lane_vec[1]),
      .lane2_vec  (lane_vec[2]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Every word carries a byte count that a format can produce.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[35:32] != 4'd0 && rsp_tdata[35:32] <= 4'd10))
      else $error("byte count out of range");

   // A record of at most four bytes is a single word.
   a_single_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[35:32] <= 4'd4) |-> rsp_tlast)
      else $error("short record not marked last");

   // The decode stage holds a transaction only while the lane stage is full
   // and cannot move on.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (a_valid_ff && l_valid_ff && !merge_ready))
      else $error("request stalled without back-pressure");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

   // Register addresses. Only index 0 is mapped; index 1 (byte address 4) is
   // outside the register file, and a write there must leave it unchanged.
   localparam logic [2:0] ADDR_REVERSED_CODES = 3'd0;
   localparam logic [2:0] ADDR_UNMAPPED       = 3'd4;

   // Bit-reversed format codes used when reversed_codes is set. A 3-bit code
   // is reversed within its own three bits.
   localparam logic [tcvw_pkg::CodeW-1:0] REV_W0  = 4'b0000;
   localparam logic [tcvw_pkg::CodeW-1:0] REV_W3  = 4'b0001;
   localparam logic [tcvw_pkg::CodeW-1:0] REV_W5  = 4'b1000;
   localparam logic [tcvw_pkg::CodeW-1:0] REV_W8  = 4'b0100;
   localparam logic [tcvw_pkg::CodeW-1:0] REV_W11 = 4'b0101;
   localparam logic [tcvw_pkg::CodeW-1:0] REV_W13 = 4'b1100;
   localparam logic [tcvw_pkg::CodeW-1:0] REV_W16 = 4'b0010;
   localparam logic [tcvw_pkg::CodeW-1:0] REV_W19 = 4'b0011;
   localparam logic [tcvw_pkg::CodeW-1:0] REV_W21 = 4'b0110;
   localparam logic [tcvw_pkg::CodeW-1:0] REV_W24 = 4'b1110;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_PERCENT = 14;

   // One word of a packed record as the result channel should carry it.
   typedef struct {
      logic [tcvw_pkg::WordW-1:0]  word;
      logic [tcvw_pkg::CountW-1:0] count;
      logic                        last;
   } record_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [tcvw_pkg::ReqDataW-1:0] req_tdata = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [tcvw_pkg::RspDataW-1:0] rsp_tdata;
   logic                          rsp_tlast;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [2:0]                    csr_paddr = '0;
   logic [31:0]                   csr_pwdata = '0;
   logic [31:0]                   csr_prdata;
   logic                          csr_pready;

   // Requests waiting to be offered, and the record words the predictor has
   // produced for requests already accepted but not yet seen on the output.
   logic [tcvw_pkg::ReqDataW-1:0] pending_requests[$];
   record_word_type               expected_words[$];

   // The testbench's own copy of the single configuration bit.
   logic codes_reversed = 1'b0;
   // When set, neither side inserts bubbles.
   logic steady_flow = 1'b0;

   int mismatches = 0;
   int cycles = 0;
   int records_accepted = 0;
   int words_checked = 0;
   int records_by_setting[2] = '{0, 0};

   three_channel_variable_width_packer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Builds a request payload: [23:0] first channel, [47:24] second channel,
   // [71:48] third channel, [75:72] event mark, [80:76] bit width, rest zero.
   function automatic logic [tcvw_pkg::ReqDataW-1:0] pack_request(
         input logic [tcvw_pkg::ChanW-1:0]  first_ch,
         input logic [tcvw_pkg::ChanW-1:0]  second_ch,
         input logic [tcvw_pkg::ChanW-1:0]  third_ch,
         input logic [tcvw_pkg::MarkW-1:0]  mark,
         input logic [tcvw_pkg::WidthW-1:0] width);
      logic [tcvw_pkg::ReqDataW-1:0] d;
      d = '0;
      d[23:0]  = first_ch;
      d[47:24] = second_ch;
      d[71:48] = third_ch;
      d[75:72] = mark;
      d[80:76] = width;
      return d;
   endfunction

   // Works out the record for one accepted request and queues its words.
   // The width selects channel bits, code, code length and byte count; the
   // mark and code form the header, and the three channels' low bits follow
   // one after another starting just above the code.
   task automatic predict_record(input logic [tcvw_pkg::ReqDataW-1:0] d);
      logic [tcvw_pkg::WidthW-1:0] width;
      logic [tcvw_pkg::CodeW-1:0]  lit_code;
      logic [tcvw_pkg::CodeW-1:0]  rev_code;
      logic [tcvw_pkg::CodeW-1:0]  code;
      logic [tcvw_pkg::ChanW-1:0]  chan_mask;
      logic [tcvw_pkg::RecW-1:0]   rec;
      int                          chan_bits;
      int                          code_len;
      int                          nbytes;
      int                          pos;
      int                          nwords;
      record_word_type             w;
      width = d[80:76];
      if (width == 0) begin
         chan_bits = 0;  lit_code = tcvw_pkg::CODE_W0;  rev_code = REV_W0;
         code_len = 4; nbytes = 1;
      end else if (width <= 3) begin
         chan_bits = 3;  lit_code = tcvw_pkg::CODE_W3;  rev_code = REV_W3;
         code_len = 3; nbytes = 2;
      end else if (width <= 5) begin
         chan_bits = 5;  lit_code = tcvw_pkg::CODE_W5;  rev_code = REV_W5;
         code_len = 4; nbytes = 3;
      end else if (width <= 8) begin
         chan_bits = 8;  lit_code = tcvw_pkg::CODE_W8;  rev_code = REV_W8;
         code_len = 4; nbytes = 4;
      end else if (width <= 11) begin
         chan_bits = 11; lit_code = tcvw_pkg::CODE_W11; rev_code = REV_W11;
         code_len = 3; nbytes = 5;
      end else if (width <= 13) begin
         chan_bits = 13; lit_code = tcvw_pkg::CODE_W13; rev_code = REV_W13;
         code_len = 4; nbytes = 6;
      end else if (width <= 16) begin
         chan_bits = 16; lit_code = tcvw_pkg::CODE_W16; rev_code = REV_W16;
         code_len = 4; nbytes = 7;
      end else if (width <= 19) begin
         chan_bits = 19; lit_code = tcvw_pkg::CODE_W19; rev_code = REV_W19;
         code_len = 3; nbytes = 8;
      end else if (width <= 21) begin
         chan_bits = 21; lit_code = tcvw_pkg::CODE_W21; rev_code = REV_W21;
         code_len = 4; nbytes = 9;
      end else begin
         chan_bits = 24; lit_code = tcvw_pkg::CODE_W24; rev_code = REV_W24;
         code_len = 4; nbytes = 10;
      end
      code = codes_reversed ? rev_code : lit_code;
      chan_mask = (chan_bits == 0) ? '0 :
                  ({tcvw_pkg::ChanW{1'b1}} >> (tcvw_pkg::ChanW - chan_bits));
      rec = '0;
      rec[3:0] = d[75:72];
      rec[7:4] = code;
      pos = 4 + code_len;
      for (int k = 0; k < tcvw_pkg::NumLanes; k++) begin
         rec = rec | (tcvw_pkg::RecW'(d[k*tcvw_pkg::ChanW +: tcvw_pkg::ChanW] & chan_mask)
                      << pos);
         pos = pos + chan_bits;
      end
      nwords = (nbytes + 3) / 4;
      for (int k = 0; k < nwords; k++) begin
         w.word  = rec[k*tcvw_pkg::WordW +: tcvw_pkg::WordW];
         w.count = tcvw_pkg::CountW'(nbytes);
         w.last  = (k == nwords - 1);
         expected_words.push_back(w);
      end
      records_accepted++;
      records_by_setting[codes_reversed]++;
   endtask

   // Channel values: half full random, with small signed values and the
   // extremes of the two's complement range mixed in.
   function automatic logic [tcvw_pkg::ChanW-1:0] random_channel();
      logic [tcvw_pkg::ChanW-1:0] v;
      case ($urandom_range(5))
         0: v = tcvw_pkg::ChanW'($urandom_range(15));
         1: v = -tcvw_pkg::ChanW'($urandom_range(16));
         2: begin
            case ($urandom_range(3))
               0: v = '0;
               1: v = '1;
               2: v = 24'h800000;
               default: v = 24'h7FFFFF;
            endcase
         end
         default: v = tcvw_pkg::ChanW'($urandom);
      endcase
      return v;
   endfunction

   task automatic queue_random_requests(input int count);
      for (int i = 0; i < count; i++)
         pending_requests.push_back(pack_request(random_channel(), random_channel(),
                                                 random_channel(),
                                                 tcvw_pkg::MarkW'($urandom),
                                                 tcvw_pkg::WidthW'($urandom_range(31))));
   endtask

   task automatic note_mismatch(input string what, input record_word_type exp_word);
      mismatches++;
      if (mismatches <= 10)
         $display({"MISMATCH (%s) at cycle %0d: expected word %h count %0d last %0b,",
                   " got word %h count %0d last %0b"},
                  what, cycles, exp_word.word, exp_word.count, exp_word.last,
                  rsp_tdata[31:0], rsp_tdata[35:32], rsp_tlast);
   endtask

   // One APB transfer: setup cycle, then access cycle. A read is compared
   // against the testbench's copy of the register in the middle of the access
   // cycle; a write lands at the edge that closes the access cycle.
   task automatic csr_access(input logic is_write, input logic [2:0] addr,
                             input logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (!is_write && csr_prdata !== {31'b0, codes_reversed}) begin
         mismatches++;
         if (mismatches <= 10)
            $display("MISMATCH (register read) at cycle %0d: expected %h, got %h",
                     cycles, {31'b0, codes_reversed}, csr_prdata);
      end
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (is_write && addr == ADDR_REVERSED_CODES)
         codes_reversed = data[0];
   endtask

   // Waits until every queued request has been taken and every predicted
   // word has come back, then lets the pipeline settle.
   task automatic wait_until_drained();
      while (pending_requests.size() != 0 || req_tvalid || expected_words.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request driver. A transaction completes at an edge where tvalid and
   // tready are both high; the predictor runs on the payload that was on the
   // bus at that edge. A new payload is loaded only when the bus is free, and
   // about one cycle in seven is left empty unless steady flow is on.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready)
            predict_record(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 &&
                (steady_flow || $urandom_range(99) >= IDLE_PERCENT)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_requests.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result side back-pressure, with the same rate of stalls.
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Result monitor: every accepted word is matched, field by field, with the
   // oldest prediction. A word with nothing predicted is a failure as well.
   always @(posedge clock) begin
      record_word_type head;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            head = '{word: '0, count: '0, last: 1'b0};
            note_mismatch("unexpected transaction", head);
         end else begin
            head = expected_words.pop_front();
            words_checked++;
            if (rsp_tdata[31:0] !== head.word || rsp_tdata[35:32] !== head.count ||
                rsp_tlast !== head.last)
               note_mismatch("record word", head);
         end
      end
   end

   // Watchdog: a stuck handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still outstanding",
                  cycles, expected_words.size());
         $display("three_channel_variable_width_packer regression: fail");
         $finish;
      end
   end

   initial begin
      logic [tcvw_pkg::WidthW-1:0] edge_widths[19];
      logic [tcvw_pkg::ChanW-1:0]  fill;
      edge_widths = '{5'd0, 5'd1, 5'd3, 5'd4, 5'd5, 5'd6, 5'd8, 5'd9, 5'd11, 5'd12,
                      5'd13, 5'd14, 5'd16, 5'd17, 5'd19, 5'd20, 5'd21, 5'd22, 5'd31};

      // Directed part, under the reset setting (literal codes): both ends of
      // every width range, so every format and both code lengths appear, with
      // channels at all-ones, zero, and the sign-bit extremes, and both
      // extreme marks. Width 0 gives the single-word, header-only record, and
      // widths 22 and 31 both fall into the 24-bit format.
      for (int i = 0; i < 19; i++) begin
         case (i % 4)
            0: fill = '1;
            1: fill = '0;
            2: fill = 24'h800000;
            default: fill = 24'h7FFFFF;
         endcase
         pending_requests.push_back(pack_request(fill, ~fill, fill ^ 24'h5A5A5A,
                                                 (i % 2) ? 4'hF : 4'h0, edge_widths[i]));
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      csr_access(1'b0, ADDR_REVERSED_CODES, '0);
      wait_until_drained();

      // Reversed codes.
      csr_access(1'b1, ADDR_REVERSED_CODES, 32'h0000_0001);
      csr_access(1'b0, ADDR_REVERSED_CODES, '0);
      queue_random_requests(90);
      wait_until_drained();

      // A wide value with bit 0 clear: only bit 0 counts, so this returns to
      // literal codes. This phase also runs with no bubbles on either side.
      csr_access(1'b1, ADDR_REVERSED_CODES, 32'hFFFF_FFFE);
      csr_access(1'b0, ADDR_REVERSED_CODES, '0);
      steady_flow = 1'b1;
      queue_random_requests(90);
      wait_until_drained();
      steady_flow = 1'b0;

      // All ones selects reversed codes; the write to an unmapped address
      // that follows must not disturb it.
      csr_access(1'b1, ADDR_REVERSED_CODES, 32'hFFFF_FFFF);
      csr_access(1'b1, ADDR_UNMAPPED, 32'h0000_0000);
      csr_access(1'b0, ADDR_REVERSED_CODES, '0);
      queue_random_requests(90);
      wait_until_drained();

      // Back to literal codes for the last stretch.
      csr_access(1'b1, ADDR_REVERSED_CODES, 32'h0000_0000);
      csr_access(1'b0, ADDR_REVERSED_CODES, '0);
      queue_random_requests(80);
      wait_until_drained();

      $display({"Covered %0d records (%0d with literal codes, %0d with reversed codes),",
                " %0d words checked."},
               records_accepted, records_by_setting[0], records_by_setting[1], words_checked);
      $display({"Register writes included a wide value, all ones and an unmapped address;",
                " %0d mismatches."},
               mismatches);
      if (mismatches == 0) begin
         $display("three_channel_variable_width_packer regression: pass");
      end else begin
         $display("three_channel_variable_width_packer regression: fail");
      end
      $finish;
   end

endmodule
